// ----- sv/checked_integer_alu_unit_macros.svh -----
// assertion macros for the checked alu
`ifndef CHECKED_INTEGER_ALU_UNIT_MACROS_SVH
`define CHECKED_INTEGER_ALU_UNIT_MACROS_SVH

// property p must hold on every rising clock edge outside reset
`define CIA_ASSERT(label, p, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (p)) else $error(msg);

// implication a |=> b outside reset
`define CIA_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- sv/cia_pkg.sv -----
package cia_pkg;

  localparam int W = 64;
  localparam int IDX_W = 7;
  // one quotient bit per stage
  localparam int DIV_STAGES = 64;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_REM = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_REMZ = 2'd3;

  // per-item control carried down the pipe
  typedef struct packed {
    logic [2:0] mode;
    logic       neg_a;
    logic       neg_b;
    logic       pre_done;   // result decided before the long path
    logic [1:0] pre_status;
    logic [63:0] pre_result;
  } ctl_t;

endpackage

// ----- sv/checked_integer_alu_unit.sv -----
// channel | dir | tdata fields (lsb first)                     | bytes
// s_axis  | in  | mode[2:0], operand_a[66:3], operand_b[130:67] | 17
// m_axis  | out | result[63:0], status[65:64]                   | 9
//
// the pipe holds a decode stage, 64 restoring division steps (one quotient
// bit per stage), a stage for multiply partial products, and a stage for
// sign fix-up and the output register; the length is set by the divider
// stage count. one item per cycle is accepted when the output slot is empty
// or being taken. a stall freezes the whole pipe at once (global enable), so
// nothing is lost or repeated. rst is synchronous and clears only the valid bits.
module checked_integer_alu_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // mode, operand_a, operand_b, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // result, status, zero pad
);
  `include "checked_integer_alu_unit_macros.svh"

  localparam int N = cia_pkg::DIV_STAGES;

  logic adv;
  logic [2:0]  in_mode;
  logic [63:0] in_a, in_b;

  assign in_mode = s_axis_tdata[2:0];
  assign in_a    = s_axis_tdata[66:3];
  assign in_b    = s_axis_tdata[130:67];

  // the pipe moves whenever the output slot is empty or being taken
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: decode, magnitudes, add/sub and early special cases
  cia_pkg::ctl_t c0_next;
  logic [63:0] sum, dif;

  always_comb begin
    sum = in_a + in_b;
    dif = in_a - in_b;
    c0_next.mode = in_mode;
    c0_next.neg_a = in_a[63];
    c0_next.neg_b = in_b[63];
    c0_next.pre_done = 1'b1;
    c0_next.pre_status = cia_pkg::ST_OK;
    c0_next.pre_result = '0;
    case (in_mode)
      cia_pkg::MODE_ADD: begin
        if (((in_a ^ sum) & (in_b ^ sum)) >> 63 != 64'd0)
          c0_next.pre_status = cia_pkg::ST_OVF;
        else c0_next.pre_result = sum;
      end
      cia_pkg::MODE_SUB: begin
        if (((in_a ^ in_b) & (in_a ^ dif)) >> 63 != 64'd0)
          c0_next.pre_status = cia_pkg::ST_OVF;
        else c0_next.pre_result = dif;
      end
      cia_pkg::MODE_MUL: c0_next.pre_done = 1'b0;
      cia_pkg::MODE_DIV, cia_pkg::MODE_REM: begin
        if (in_b == 64'd0)
          c0_next.pre_status = (in_mode == cia_pkg::MODE_DIV) ?
                               cia_pkg::ST_DIVZ : cia_pkg::ST_REMZ;
        else if (in_a == 64'h8000_0000_0000_0000 && in_b == '1)
          c0_next.pre_status = (in_mode == cia_pkg::MODE_DIV) ?
                               cia_pkg::ST_OVF : cia_pkg::ST_OK;
        else c0_next.pre_done = 1'b0;
      end
      default: ;
    endcase
  end

  // divider stages: restoring, one quotient bit each; the multiplier operands
  // ride along and the product is built in the last two stages
  logic          dv   [N+1];
  cia_pkg::ctl_t dc   [N+1];
  logic [63:0]   drem [N+1];
  logic [63:0]   dquo [N+1];
  logic [63:0]   dden [N+1];
  logic [63:0]   dsa  [N+1];
  logic [63:0]   dsb  [N+1];

  // stage 0 registers feed the first divider step
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= s_axis_tvalid;
    if (adv) begin
      dc[0]   <= c0_next;
      dsa[0]  <= in_a;
      dsb[0]  <= in_b;
      drem[0] <= '0;
      dquo[0] <= in_a[63] ? (64'd0 - in_a) : in_a;
      dden[0] <= in_b[63] ? (64'd0 - in_b) : in_b;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_div
    logic [64:0] sh;
    logic [64:0] tr;
    always_comb begin
      sh = {drem[g], dquo[g][63]};
      tr = sh - {1'b0, dden[g]};
    end
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else if (adv) dv[g+1] <= dv[g];
      if (adv) begin
        dc[g+1]   <= dc[g];
        dden[g+1] <= dden[g];
        dsa[g+1]  <= dsa[g];
        dsb[g+1]  <= dsb[g];
        if (!tr[64]) begin
          drem[g+1] <= tr[63:0];
          dquo[g+1] <= {dquo[g][62:0], 1'b1};
        end else begin
          drem[g+1] <= sh[63:0];
          dquo[g+1] <= {dquo[g][62:0], 1'b0};
        end
      end
    end
  end

  // multiply stage: four 32x32 unsigned partial products
  logic          vm;
  cia_pkg::ctl_t cm;
  logic [63:0]   ll, lh, hl, hh, ma_m, mb_m, qm, rm;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= dv[N];
    if (adv) begin
      cm   <= dc[N];
      ll   <= {32'd0, dsa[N][31:0]}  * {32'd0, dsb[N][31:0]};
      lh   <= {32'd0, dsa[N][31:0]}  * {32'd0, dsb[N][63:32]};
      hl   <= {32'd0, dsa[N][63:32]} * {32'd0, dsb[N][31:0]};
      hh   <= {32'd0, dsa[N][63:32]} * {32'd0, dsb[N][63:32]};
      ma_m <= dsa[N];
      mb_m <= dsb[N];
      qm   <= dquo[N];
      rm   <= drem[N];
    end
  end

  // final stage: sum partials, signed correction, overflow, sign fix-up
  logic [127:0] prod;
  logic [63:0]  hi_c;
  logic [63:0]  res_next;
  logic [1:0]   st_next;
  always_comb begin
    prod = {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
    hi_c = prod[127:64] - (ma_m[63] ? mb_m : 64'd0) - (mb_m[63] ? ma_m : 64'd0);
    res_next = cm.pre_result;
    st_next  = cm.pre_status;
    if (!cm.pre_done) begin
      case (cm.mode)
        cia_pkg::MODE_MUL: begin
          if (hi_c != {64{prod[63]}}) begin
            st_next = cia_pkg::ST_OVF;
            res_next = '0;
          end else res_next = prod[63:0];
        end
        cia_pkg::MODE_DIV:
          res_next = (cm.neg_a != cm.neg_b) ? (64'd0 - qm) : qm;
        cia_pkg::MODE_REM:
          res_next = cm.neg_a ? (64'd0 - rm) : rm;
        default: res_next = '0;
      endcase
    end
  end

  logic [63:0] out_res;
  logic [1:0]  out_st;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vm;
    if (adv) begin
      out_res <= res_next;
      out_st  <= st_next;
    end
  end

  assign m_axis_tdata = {6'd0, out_st, out_res};

  // an error status always carries a zero result
  `CIA_ASSERT(a_err_zero, !m_axis_tvalid || out_st == cia_pkg::ST_OK || out_res == 64'd0, "error with nonzero result")
  // a held output stays put
  `CIA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_res) && $stable(out_st), "stalled output changed")
  // the input side is ready exactly when the pipe advances
  `CIA_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
endmodule
